// ----- hdl/hbq_pkg.sv -----
// Shared types and constants for the binary min-heap queue.
// No dependencies; imported by every module of the block.
`default_nettype none

package hbq_pkg;

    localparam int KEY_W  = 32;
    localparam int STAT_W = 2;
    localparam int CAP_W  = 5;

    localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

    // command codes
    localparam logic CMD_INSERT = 1'b0;
    localparam logic CMD_REMOVE = 1'b1;

    // status codes
    localparam logic [STAT_W-1:0] STAT_OK    = 2'd0;
    localparam logic [STAT_W-1:0] STAT_FULL  = 2'd1;
    localparam logic [STAT_W-1:0] STAT_EMPTY = 2'd2;

    // register indexes (word address)
    localparam logic REG_CAPACITY = 1'b0;

    localparam logic signed [KEY_W-1:0] KEY_NONE = -32'sd1;
    localparam logic signed [KEY_W-1:0] KEY_ZERO = 32'sd0;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_UP,
        ST_UP_WR,
        ST_ROOT,
        ST_DOWN,
        ST_RESULT
    } t_state;

    typedef struct packed {
        logic signed [KEY_W-1:0] key;
        logic [STAT_W-1:0]       status;
    } t_result;

endpackage

`default_nettype wire

// ----- hdl/hbq_mem.sv -----
// Heap storage: one write port, two read ports, registered read data.
// Depends on hbq_pkg for the key width.
`default_nettype none

module hbq_mem
    import hbq_pkg::*;
#(
    parameter int DEPTH = 16
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_we,
    input  wire logic [$clog2(DEPTH)-1:0]      i_waddr,
    input  wire logic signed [KEY_W-1:0]       i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0]      i_raddr_a,
    input  wire logic [$clog2(DEPTH)-1:0]      i_raddr_b,
    output logic signed [KEY_W-1:0]            o_rdata_a,
    output logic signed [KEY_W-1:0]            o_rdata_b
);

    logic signed [KEY_W-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        o_rdata_a <= r_mem[i_raddr_a];
        o_rdata_b <= r_mem[i_raddr_b];
    end

endmodule

`default_nettype wire

// ----- hdl/hbq_ctrl.sv -----
// Sift sequencer: walks the hole up or down the heap, one level per cycle.
// Depends on hbq_pkg; drives the ports of hbq_mem.
`default_nettype none

module hbq_ctrl
    import hbq_pkg::*;
#(
    parameter int DEPTH = 16
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic [CAP_W-1:0]              i_cap,
    input  wire logic                          i_in_valid,
    output logic                               o_in_ready,
    input  wire logic                          i_cmd,
    input  wire logic signed [KEY_W-1:0]       i_key,
    output logic                               o_res_valid,
    input  wire logic                          i_res_ready,
    output t_result                            o_res,
    output logic                               o_we,
    output logic [$clog2(DEPTH)-1:0]           o_waddr,
    output logic signed [KEY_W-1:0]            o_wdata,
    output logic [$clog2(DEPTH)-1:0]           o_raddr_a,
    output logic [$clog2(DEPTH)-1:0]           o_raddr_b,
    input  wire logic signed [KEY_W-1:0]       i_rdata_a,
    input  wire logic signed [KEY_W-1:0]       i_rdata_b
);

    localparam int IW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam int XW = IW + 2;
    localparam int LW = (CW > CAP_W) ? CW : CAP_W;

    t_state                  r_state, n_state;
    logic [CW-1:0]           r_count, n_count;
    logic [IW-1:0]           r_hole, n_hole;
    logic signed [KEY_W-1:0] r_key, n_key;
    t_result                 r_res, n_res;

    function automatic logic [IW-1:0] parent_of(input logic [IW-1:0] h);
        logic [IW-1:0] d;
        d = h - 1'b1;
        return d >> 1;
    endfunction

    function automatic logic [XW-1:0] left_of(input logic [IW-1:0] h);
        return {1'b0, h, 1'b0} + XW'(1);
    endfunction

    logic [LW-1:0] cap_ext, lim;
    logic          full;
    logic          in_acc;
    logic [XW-1:0] l_idx, r_idx;
    logic          l_ok, take_l, take_r;
    logic signed [KEY_W-1:0] best_l;
    logic [IW-1:0] s_idx, p_idx;

    // capacity saturates at the store depth
    assign cap_ext = LW'(i_cap);
    assign lim     = (cap_ext > LW'(DEPTH)) ? LW'(DEPTH) : cap_ext;
    assign full    = LW'(r_count) >= lim;

    assign o_in_ready  = (r_state == ST_IDLE);
    assign in_acc      = i_in_valid && o_in_ready;
    assign o_res_valid = (r_state == ST_RESULT);
    assign o_res       = r_res;

    // child selection: left tested first, right wins only when strictly smaller
    assign l_idx  = left_of(r_hole);
    assign r_idx  = l_idx + XW'(1);
    assign l_ok   = l_idx < XW'(r_count);
    assign take_l = l_ok && (i_rdata_a < r_key);
    assign best_l = take_l ? i_rdata_a : r_key;
    assign take_r = (r_idx < XW'(r_count)) && (i_rdata_b < best_l);
    assign s_idx  = take_r ? r_idx[IW-1:0] : l_idx[IW-1:0];
    assign p_idx  = parent_of(r_hole);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else begin
            r_count <= n_count;
        end
        r_hole <= n_hole;
        r_key  <= n_key;
        r_res  <= n_res;
    end

    always_comb begin
        n_state   = r_state;
        n_count   = r_count;
        n_hole    = r_hole;
        n_key     = r_key;
        n_res     = r_res;
        o_we      = 1'b0;
        o_waddr   = r_hole;
        o_wdata   = r_key;
        o_raddr_a = p_idx;
        o_raddr_b = r_hole;
        unique case (r_state)
            ST_IDLE: begin
                if (in_acc) begin
                    if (i_cmd == CMD_INSERT) begin
                        n_res.key = KEY_ZERO;
                        n_key     = i_key;
                        if (full) begin
                            n_res.status = STAT_FULL;
                            n_state      = ST_RESULT;
                        end else begin
                            n_res.status = STAT_OK;
                            n_count      = r_count + 1'b1;
                            n_hole       = r_count[IW-1:0];
                            if (r_count == '0) begin
                                o_we    = 1'b1;
                                o_waddr = '0;
                                o_wdata = i_key;
                                n_state = ST_RESULT;
                            end else begin
                                o_raddr_a = parent_of(r_count[IW-1:0]);
                                n_state   = ST_UP;
                            end
                        end
                    end else begin
                        if (r_count == '0) begin
                            n_res.key    = KEY_NONE;
                            n_res.status = STAT_EMPTY;
                            n_state      = ST_RESULT;
                        end else begin
                            // fetch root and last entry together
                            o_raddr_a = '0;
                            o_raddr_b = IW'(r_count - 1'b1);
                            n_count   = r_count - 1'b1;
                            n_hole    = '0;
                            n_state   = ST_ROOT;
                        end
                    end
                end
            end
            ST_UP: begin
                if (r_key < i_rdata_a) begin
                    // parent drops into the hole, hole moves up
                    o_we      = 1'b1;
                    o_wdata   = i_rdata_a;
                    n_hole    = p_idx;
                    o_raddr_a = parent_of(p_idx);
                    n_state   = (p_idx == '0) ? ST_UP_WR : ST_UP;
                end else begin
                    o_we    = 1'b1;
                    n_state = ST_RESULT;
                end
            end
            ST_UP_WR: begin
                o_we    = 1'b1;
                n_state = ST_RESULT;
            end
            ST_ROOT: begin
                n_res.key    = i_rdata_a;
                n_res.status = STAT_OK;
                n_key        = i_rdata_b;
                o_raddr_a    = l_idx[IW-1:0];
                o_raddr_b    = r_idx[IW-1:0];
                n_state      = (r_count == '0) ? ST_RESULT : ST_DOWN;
            end
            ST_DOWN: begin
                o_we = 1'b1;
                if (take_l || take_r) begin
                    o_wdata   = take_r ? i_rdata_b : i_rdata_a;
                    n_hole    = s_idx;
                    o_raddr_a = IW'(left_of(s_idx));
                    o_raddr_b = IW'(left_of(s_idx) + XW'(1));
                end else begin
                    n_state = ST_RESULT;
                end
            end
            ST_RESULT: begin
                if (i_res_ready) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(DEPTH))
        else $error("entry count above depth");

    a_insert_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc && (i_cmd == CMD_INSERT) && !full |=> r_count == $past(r_count) + 1'b1)
        else $error("insert did not grow the heap");

    a_remove_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc && (i_cmd == CMD_REMOVE) && (r_count != '0)
        |=> r_count == $past(r_count) - 1'b1)
        else $error("remove did not shrink the heap");

    a_hole_in_heap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_UP) || (r_state == ST_UP_WR) |-> CW'(r_hole) < r_count)
        else $error("sift-up hole outside the heap");

endmodule

`default_nettype wire

// ----- hdl/binary_min_heap_queue.sv -----
// Top level of the binary min-heap queue: APB capacity register, output item
// register, sift sequencer and heap memory. Depends on hbq_pkg, hbq_ctrl, hbq_mem.
//
// Channel  | Dir | Signals                            | Contents
// s_axis   | in  | tvalid tready tdata[31:0] tuser[0] | key_in ; command
// m_axis   | out | tvalid tready tdata[31:0] tuser[1:0]| key_out ; status
// apb      | in  | psel penable pwrite paddr pwdata   | capacity at byte address 0
//
// Sequencing: an insert into an empty heap is written straight to the root and a
//   refused one writes nothing; any other insert climbs level by level. A remove
//   reports empty on an empty heap, else fetches root and last entry together and
//   sinks level by level. Each level costs one read-compare-write through the
//   memory, whose read data is registered.
// Reset: synchronous, active low; clears the entry count and sets capacity to
//   16. The heap memory is not cleared; only entries below the count are read.
// Stalls: the finished item sits in the output register, so the next item is
//   taken while it waits; a further result holds until m_axis_tready.
`default_nettype none

module binary_min_heap_queue
    import hbq_pkg::*;
#(
    parameter int DEPTH = 16
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    // input items
    input  wire logic              s_axis_tvalid,
    output logic                   s_axis_tready,
    input  wire logic [31:0]       s_axis_tdata,   // [31:0] key_in
    input  wire logic [0:0]        s_axis_tuser,   // [0] command
    // result items
    output logic                   m_axis_tvalid,
    input  wire logic              m_axis_tready,
    output logic [31:0]            m_axis_tdata,   // [31:0] key_out
    output logic [1:0]             m_axis_tuser,   // [1:0] status
    // configuration
    input  wire logic              psel,
    input  wire logic              penable,
    input  wire logic              pwrite,
    input  wire logic [2:0]        paddr,
    input  wire logic [31:0]       pwdata,
    output logic [31:0]            prdata,
    output logic                   pready
);

    localparam int IW = $clog2(DEPTH);

    logic [CAP_W-1:0] r_cap;

    // result path between sequencer and output register
    logic    res_valid, res_ready;
    t_result res;
    logic    r_out_valid;
    t_result r_out;

    // memory ports
    logic                    mem_we;
    logic [IW-1:0]           mem_waddr, mem_raddr_a, mem_raddr_b;
    logic signed [KEY_W-1:0] mem_wdata, mem_rdata_a, mem_rdata_b;

    // ---- APB register: word address is paddr[2] ----
    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cap <= CAP_RESET;
        end else if (psel && penable && pwrite && pready && (paddr[2] == REG_CAPACITY)) begin
            r_cap <= pwdata[CAP_W-1:0];
        end
    end

    assign prdata = (paddr[2] == REG_CAPACITY) ? {{(32-CAP_W){1'b0}}, r_cap} : 32'd0;

    // ---- output register: loads when empty or being drained ----
    assign res_ready = !r_out_valid || m_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (res_ready) begin
            r_out_valid <= res_valid;
        end
        if (res_valid && res_ready) begin
            r_out <= res;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out.key;
    assign m_axis_tuser  = r_out.status;

    hbq_ctrl #(
        .DEPTH(DEPTH)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cap       (r_cap),
        .i_in_valid  (s_axis_tvalid),
        .o_in_ready  (s_axis_tready),
        .i_cmd       (s_axis_tuser[0]),
        .i_key       (s_axis_tdata),
        .o_res_valid (res_valid),
        .i_res_ready (res_ready),
        .o_res       (res),
        .o_we        (mem_we),
        .o_waddr     (mem_waddr),
        .o_wdata     (mem_wdata),
        .o_raddr_a   (mem_raddr_a),
        .o_raddr_b   (mem_raddr_b),
        .i_rdata_a   (mem_rdata_a),
        .i_rdata_b   (mem_rdata_b)
    );

    hbq_mem #(
        .DEPTH(DEPTH)
    ) u_mem (
        .i_clk     (i_clk),
        .i_we      (mem_we),
        .i_waddr   (mem_waddr),
        .i_wdata   (mem_wdata),
        .i_raddr_a (mem_raddr_a),
        .i_raddr_b (mem_raddr_b),
        .o_rdata_a (mem_rdata_a),
        .o_rdata_b (mem_rdata_b)
    );

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
        && $stable(m_axis_tuser))
        else $error("stalled result item changed");

    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("second item taken while one is in the sequencer");

    a_cap_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        psel && penable && pwrite && (paddr[2] == REG_CAPACITY)
        |=> r_cap == $past(pwdata[CAP_W-1:0]))
        else $error("capacity write lost");

endmodule

`default_nettype wire
